[src/pointer_position_tracker_macros.svh]
// assertion macros for the pointer position tracker
`ifndef POINTER_POSITION_TRACKER_MACROS_SVH
`define POINTER_POSITION_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define PPT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pointer tracker check failed");
`define PPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pointer tracker check failed");
`else
`define PPT_ASSERT_IMP(label, ante, cons)
`define PPT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/ppt_pkg.sv]
// types, codes and step tables of the pointer position tracker
`timescale 1ns / 1ps

package ppt_pkg;

	localparam int POT_CAP = 228;
	localparam int POS_W   = 10;

	localparam logic [1:0] OP_POLL = 2'd0;
	localparam logic [1:0] OP_INIT = 2'd1;
	localparam logic [1:0] OP_WARP = 2'd2;

	localparam logic [2:0] KIND_NONE      = 3'd0;
	localparam logic [2:0] KIND_ST_MOUSE  = 3'd1;
	localparam logic [2:0] KIND_ALT_MOUSE = 3'd2;
	localparam logic [2:0] KIND_TRACKBALL = 3'd3;
	localparam logic [2:0] KIND_TABLET    = 3'd4;
	localparam logic [2:0] KIND_POT_MOUSE = 3'd5;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [7:0]         port_lines;
		logic               trigger_a;
		logic               trigger_b;
		logic [7:0]         pot_a;
		logic [7:0]         pot_b;
		logic [7:0]         pot_c;
		logic [7:0]         pot_d;
		logic [3:0]         pots_busy;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
	} sample_t;

	typedef struct packed {
		logic [9:0]         pos_x;
		logic [7:0]         pos_y;
		logic [2:0]         button_bits;
		logic signed [15:0] wheel_count;
		logic               start_scan;
		logic               device_found;
	} result_t;

	// gray-code quadrature step, index is previous pair then current pair
	function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
		logic signed [1:0] s;
		begin
			unique case (idx)
				4'd1, 4'd7, 4'd8, 4'd14: s = 2'sd1;
				4'd2, 4'd4, 4'd11, 4'd13: s = -2'sd1;
				default: s = 2'sd0;
			endcase
			return s;
		end
	endfunction

	// direction-and-pulse step
	function automatic logic signed [1:0] dirpulse_step(input logic [3:0] idx);
		logic signed [1:0] s;
		begin
			unique case (idx)
				4'd3, 4'd6, 4'd11, 4'd14: s = 2'sd1;
				4'd1, 4'd4, 4'd9, 4'd12: s = -2'sd1;
				default: s = 2'sd0;
			endcase
			return s;
		end
	endfunction

	// pot reading valid when bits 6 and 7 differ
	function automatic logic pot_ok(input logic [7:0] p);
		return p[7] ^ p[6];
	endfunction

	// 7-bit wrapped difference, halved toward zero
	function automatic logic signed [6:0] pot_delta(input logic [7:0] ref_v,
			input logic [7:0] now_v);
		logic [7:0]        diff;
		logic signed [7:0] d;
		logic signed [7:0] h;
		begin
			diff = now_v - ref_v;
			d = {diff[6], diff[6:0]};
			h = (d + {7'd0, d[7]}) >>> 1;
			return h[6:0];
		end
	endfunction

endpackage

[src/ppt_stream_if.sv]
// valid/ready channel carrying one word
`timescale 1ns / 1ps

interface ppt_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/pointer_position_tracker.sv]
// pointer position tracker top level
// a taken word waits in input register word_s1, then goes into result register out_q when free
// throughput: one word per cycle while result.ready stays high
// while a result waits to be taken the input register still holds one word
// arst_n clears device kind, pointer, buttons, wheel and all decode state
`timescale 1ns / 1ps

`include "pointer_position_tracker_macros.svh"

module pointer_position_tracker
	import ppt_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_data,
	ppt_stream_if.sink       sample,
	ppt_stream_if.source     result
);

	localparam logic signed [16:0] X_TOP = 17'(SCREEN_WIDTH - 1);
	localparam logic signed [16:0] Y_TOP = 17'(SCREEN_HEIGHT - 1);

	// stage and result registers
	sample_t       word_s1;
	logic          vld_s1;
	result_t       out_q;
	logic          out_vld_q;
	logic          adv;

	// tracker state
	logic [2:0]         kind_q;
	logic [POS_W-1:0]   cur_x_q, cur_y_q;
	logic [2:0]         buttons_q;
	logic signed [15:0] wheel_q;
	logic [1:0]         prev_x_q, prev_y_q;
	logic               scan_pending_q, found_q, found_port_q;
	logic [7:0]         ref_x_q, ref_y_q;
	logic [1:0]         phase_q;

	// next state
	logic [POS_W-1:0]   cur_x_d, cur_y_d;
	logic [2:0]         buttons_d;
	logic signed [15:0] wheel_d;
	logic [1:0]         prev_x_d, prev_y_d;
	logic               scan_pending_d, found_d, found_port_d;
	logic [7:0]         ref_x_d, ref_y_d;
	logic [1:0]         phase_d;
	logic               start;

	// decode helpers
	logic [3:0]         nib0;
	logic [1:0]         pair_x, pair_y;
	logic signed [1:0]  step_x, step_y, wheel_step;
	logic [POS_W-1:0]   tgt_x, tgt_y, quad_x, quad_y, pot_x_pos, pot_y_pos;
	logic [7:0]         cap_x, cap_y;
	logic [POS_W-1:0]   tab_x [0:POT_CAP];
	logic [POS_W-1:0]   tab_y [0:POT_CAP];
	logic               ok0, ok1, port_sel;
	logic [7:0]         sel_px, sel_py;
	logic signed [6:0]  dx, dy;
	logic [3:0]         sel_nib;
	logic               sel_trg;

	function automatic logic [POS_W-1:0] clamp_pos(input logic signed [16:0] v,
			input logic signed [16:0] top);
		logic [POS_W-1:0] r;
		begin
			if (v < 17'sd0) begin
				r = '0;
			end else if (v > top) begin
				r = top[POS_W-1:0];
			end else begin
				r = v[POS_W-1:0];
			end
			return r;
		end
	endfunction

	// tablet scaling tables, worked out at elaboration
	for (genvar i = 0; i <= POT_CAP; i++) begin : g_scale
		assign tab_x[i] = POS_W'((i * (SCREEN_WIDTH - 1)) / POT_CAP);
		assign tab_y[i] = POS_W'((i * (SCREEN_HEIGHT - 1)) / POT_CAP);
	end

	assign adv          = vld_s1 && (!out_vld_q || result.ready);
	assign sample.ready = !vld_s1 || adv;
	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	// line pairs for the quadrature kinds
	always_comb begin
		nib0 = word_s1.port_lines[3:0];
		if (kind_q == KIND_ALT_MOUSE) begin
			pair_x = {nib0[3], nib0[1]};
			pair_y = {nib0[2], nib0[0]};
		end else begin
			pair_x = {nib0[0], nib0[1]};
			pair_y = {nib0[2], nib0[3]};
		end
		if (kind_q == KIND_TRACKBALL) begin
			step_x = dirpulse_step({prev_x_q, pair_x});
			step_y = dirpulse_step({prev_y_q, pair_y});
		end else begin
			step_x = gray_step({prev_x_q, pair_x});
			step_y = gray_step({prev_y_q, pair_y});
		end
		quad_x = clamp_pos(17'($signed({1'b0, cur_x_q})) + 17'(step_x), X_TOP);
		quad_y = clamp_pos(17'($signed({1'b0, cur_y_q})) + 17'(step_y), Y_TOP);
		tgt_x  = clamp_pos(17'(word_s1.target_x), X_TOP);
		tgt_y  = clamp_pos(17'(word_s1.target_y), Y_TOP);
	end

	// tablet and pot mouse decode
	always_comb begin
		cap_x = (word_s1.pot_a > 8'(POT_CAP)) ? 8'(POT_CAP) : word_s1.pot_a;
		cap_y = (word_s1.pot_b > 8'(POT_CAP)) ? 8'(POT_CAP) : word_s1.pot_b;
		ok0 = pot_ok(word_s1.pot_a) && pot_ok(word_s1.pot_b);
		ok1 = pot_ok(word_s1.pot_c) && pot_ok(word_s1.pot_d);
		if (found_q) begin
			port_sel = found_port_q;
		end else begin
			port_sel = !ok0;
		end
		sel_px  = port_sel ? word_s1.pot_c : word_s1.pot_a;
		sel_py  = port_sel ? word_s1.pot_d : word_s1.pot_b;
		sel_nib = port_sel ? word_s1.port_lines[7:4] : word_s1.port_lines[3:0];
		sel_trg = port_sel ? word_s1.trigger_b : word_s1.trigger_a;
		dx = pot_delta(ref_x_q, sel_px);
		dy = pot_delta(ref_y_q, sel_py);
		pot_x_pos = clamp_pos(17'($signed({1'b0, cur_x_q})) + 17'(dx), X_TOP);
		pot_y_pos = clamp_pos(17'($signed({1'b0, cur_y_q})) + 17'(dy), Y_TOP);
		wheel_step = gray_step({phase_q, sel_nib[1:0]});
	end

	// next-state logic for the word in the input register
	always_comb begin
		cur_x_d        = cur_x_q;
		cur_y_d        = cur_y_q;
		buttons_d      = buttons_q;
		wheel_d        = wheel_q;
		prev_x_d       = prev_x_q;
		prev_y_d       = prev_y_q;
		scan_pending_d = scan_pending_q;
		found_d        = found_q;
		found_port_d   = found_port_q;
		ref_x_d        = ref_x_q;
		ref_y_d        = ref_y_q;
		phase_d        = phase_q;
		start          = 1'b0;
		unique case (word_s1.opcode)
			OP_INIT: begin
				buttons_d      = '0;
				wheel_d        = '0;
				cur_x_d        = tgt_x;
				cur_y_d        = tgt_y;
				prev_x_d       = pair_x;
				prev_y_d       = pair_y;
				found_d        = 1'b0;
				phase_d        = '0;
				scan_pending_d = (kind_q == KIND_TABLET) || (kind_q == KIND_POT_MOUSE);
				start          = scan_pending_d;
			end
			OP_WARP: begin
				cur_x_d = tgt_x;
				cur_y_d = tgt_y;
			end
			OP_POLL: begin
				unique case (kind_q)
					KIND_ST_MOUSE, KIND_ALT_MOUSE, KIND_TRACKBALL: begin
						cur_x_d   = quad_x;
						cur_y_d   = quad_y;
						prev_x_d  = pair_x;
						prev_y_d  = pair_y;
						buttons_d = {1'b0, ~word_s1.trigger_b, ~word_s1.trigger_a};
					end
					KIND_TABLET: begin
						if (!(scan_pending_q && (word_s1.pots_busy[1:0] != 2'b00))) begin
							cur_x_d        = tab_x[cap_x];
							cur_y_d        = tab_y[cap_y];
							buttons_d      = {1'b0, ~word_s1.trigger_b, ~word_s1.trigger_a};
							scan_pending_d = 1'b1;
							start          = 1'b1;
						end
					end
					KIND_POT_MOUSE: begin
						if (!(scan_pending_q && (word_s1.pots_busy != 4'd0))) begin
							if (!found_q) begin
								if (ok0 || ok1) begin
									found_d      = 1'b1;
									found_port_d = port_sel;
									ref_x_d      = sel_px;
									ref_y_d      = sel_py;
								end
							end else if (pot_ok(sel_px) && pot_ok(sel_py)) begin
								if (dx != 7'sd0) begin
									ref_x_d = sel_px;
								end
								if (dy != 7'sd0) begin
									ref_y_d = sel_py;
								end
								cur_x_d = pot_x_pos;
								cur_y_d = pot_y_pos;
							end
							if (found_d) begin
								buttons_d = {~sel_nib[3], ~sel_nib[2], ~sel_trg};
								wheel_d   = wheel_q + 16'(wheel_step);
								phase_d   = sel_nib[1:0];
							end
							scan_pending_d = 1'b1;
							start          = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (cfg_we) begin
			kind_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (sample.ready) begin
				vld_s1 <= sample.valid;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			word_s1 <= sample.data;
		end
		if (adv) begin
			out_q.pos_x        <= cur_x_d;
			out_q.pos_y        <= cur_y_d[7:0];
			out_q.button_bits  <= buttons_d;
			out_q.wheel_count  <= wheel_d;
			out_q.start_scan   <= start;
			out_q.device_found <= found_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			buttons_q      <= '0;
			wheel_q        <= '0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			scan_pending_q <= 1'b0;
			found_q        <= 1'b0;
			found_port_q   <= 1'b0;
			ref_x_q        <= '0;
			ref_y_q        <= '0;
			phase_q        <= '0;
		end else if (adv) begin
			cur_x_q        <= cur_x_d;
			cur_y_q        <= cur_y_d;
			buttons_q      <= buttons_d;
			wheel_q        <= wheel_d;
			prev_x_q       <= prev_x_d;
			prev_y_q       <= prev_y_d;
			scan_pending_q <= scan_pending_d;
			found_q        <= found_d;
			found_port_q   <= found_port_d;
			ref_x_q        <= ref_x_d;
			ref_y_q        <= ref_y_d;
			phase_q        <= phase_d;
		end
	end

	`PPT_ASSERT_IMP(a_pos_on_screen, out_vld_q,
		(17'($signed({1'b0, cur_x_q})) <= X_TOP) && (17'($signed({1'b0, cur_y_q})) <= Y_TOP))
	`PPT_ASSERT_IMP(a_result_tracks_state, out_vld_q,
		(out_q.pos_x == cur_x_q) && (out_q.device_found == found_q) && (out_q.wheel_count == wheel_q))
	`PPT_ASSERT_IMP(a_start_marks_pending, out_vld_q && out_q.start_scan, scan_pending_q)
	`PPT_ASSERT_NEXT(a_idle_kind_holds, adv && (word_s1.opcode == OP_POLL) && (kind_q == KIND_NONE),
		$stable(cur_x_q) && $stable(cur_y_q) && $stable(wheel_q))

endmodule

[tb/sv/tb.sv]
// testbench of the pointer position tracker: predicts every result word and checks it
`timescale 1ns / 1ps

module tb;
	import ppt_pkg::*;

	localparam int SCR_W = 640;
	localparam int SCR_H = 240;

	class pointer_predictor;
		logic [2:0]  kind;
		logic [9:0]  cur_x;
		logic [9:0]  cur_y;
		logic [2:0]  buttons;
		logic [15:0] wheel;
		logic [1:0]  prev_x;
		logic [1:0]  prev_y;
		logic [1:0]  wheel_phase;
		logic        scan_pending;
		logic        found;
		logic        found_port;
		logic [7:0]  ref_x;
		logic [7:0]  ref_y;
		int          mismatches;
		result_t     expected_reports[$];
		int quad_turn[16]  = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};
		int pulse_turn[16] = '{0, -1, 0, 1, -1, 0, 1, 0, 0, -1, 0, 1, -1, 0, 1, 0};

		function new();
			kind = KIND_NONE;
			cur_x = '0;
			cur_y = '0;
			buttons = '0;
			wheel = '0;
			prev_x = '0;
			prev_y = '0;
			wheel_phase = '0;
			scan_pending = 1'b0;
			found = 1'b0;
			found_port = 1'b0;
			ref_x = '0;
			ref_y = '0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function int clamp(int v, int top);
			if (v < 0)
				return 0;
			if (v > top)
				return top;
			return v;
		endfunction

		function void place(int x, int y);
			cur_x = 10'(clamp(x, SCR_W - 1));
			cur_y = 10'(clamp(y, SCR_H - 1));
		endfunction

		function logic [1:0] pair_of(logic [3:0] nib, bit vertical);
			if (kind == KIND_ALT_MOUSE)
				return vertical ? {nib[2], nib[0]} : {nib[3], nib[1]};
			return vertical ? {nib[2], nib[3]} : {nib[0], nib[1]};
		endfunction

		function bit pot_valid(logic [7:0] p);
			return p[7] ^ p[6];
		endfunction

		// 7-bit wrapped difference, halved toward zero
		function int halved_move(logic [7:0] from, logic [7:0] to);
			int d;
			d = (to - from) & 32'h7F;
			if (d >= 64)
				d -= 128;
			return (d < 0) ? -((-d) >> 1) : (d >> 1);
		endfunction

		function void absorb_sample(sample_t s);
			result_t    r;
			logic [7:0] pots[4];
			logic [3:0] nib;
			logic [1:0] qx;
			logic [1:0] qy;
			logic [1:0] ph;
			logic [7:0] px;
			logic [7:0] py;
			bit         started;
			int         dx;
			int         dy;
			int         cap_x;
			int         cap_y;
			started = 1'b0;
			pots[0] = s.pot_a;
			pots[1] = s.pot_b;
			pots[2] = s.pot_c;
			pots[3] = s.pot_d;
			case (s.opcode)
				OP_INIT: begin
					nib = s.port_lines[3:0];
					buttons = '0;
					wheel = '0;
					place($signed(s.target_x), $signed(s.target_y));
					prev_x = pair_of(nib, 1'b0);
					prev_y = pair_of(nib, 1'b1);
					scan_pending = 1'b0;
					found = 1'b0;
					wheel_phase = '0;
					if (kind == KIND_TABLET || kind == KIND_POT_MOUSE) begin
						scan_pending = 1'b1;
						started = 1'b1;
					end
				end
				OP_WARP: begin
					place($signed(s.target_x), $signed(s.target_y));
				end
				OP_POLL: begin
					if (kind == KIND_ST_MOUSE || kind == KIND_ALT_MOUSE
							|| kind == KIND_TRACKBALL) begin
						nib = s.port_lines[3:0];
						qx = pair_of(nib, 1'b0);
						qy = pair_of(nib, 1'b1);
						if (kind == KIND_TRACKBALL)
							place(int'(cur_x) + pulse_turn[{prev_x, qx}],
								int'(cur_y) + pulse_turn[{prev_y, qy}]);
						else
							place(int'(cur_x) + quad_turn[{prev_x, qx}],
								int'(cur_y) + quad_turn[{prev_y, qy}]);
						prev_x = qx;
						prev_y = qy;
						buttons = {1'b0, ~s.trigger_b, ~s.trigger_a};
					end else if (kind == KIND_TABLET) begin
						if (!(scan_pending && s.pots_busy[1:0] != 0)) begin
							cap_x = (s.pot_a > POT_CAP) ? POT_CAP : s.pot_a;
							cap_y = (s.pot_b > POT_CAP) ? POT_CAP : s.pot_b;
							place(cap_x * (SCR_W - 1) / POT_CAP, cap_y * (SCR_H - 1) / POT_CAP);
							buttons = {1'b0, ~s.trigger_b, ~s.trigger_a};
							scan_pending = 1'b1;
							started = 1'b1;
						end
					end else if (kind == KIND_POT_MOUSE) begin
						if (!(scan_pending && s.pots_busy != 0)) begin
							if (!found) begin
								if (pot_valid(pots[0]) && pot_valid(pots[1])) begin
									found_port = 1'b0;
									ref_x = pots[0];
									ref_y = pots[1];
									found = 1'b1;
								end else if (pot_valid(pots[2]) && pot_valid(pots[3])) begin
									found_port = 1'b1;
									ref_x = pots[2];
									ref_y = pots[3];
									found = 1'b1;
								end
							end else begin
								px = pots[{found_port, 1'b0}];
								py = pots[{found_port, 1'b1}];
								if (pot_valid(px) && pot_valid(py)) begin
									dx = halved_move(ref_x, px);
									dy = halved_move(ref_y, py);
									if (dx != 0)
										ref_x = px;
									if (dy != 0)
										ref_y = py;
									place(int'(cur_x) + dx, int'(cur_y) + dy);
								end
							end
							if (found) begin
								nib = found_port ? s.port_lines[7:4] : s.port_lines[3:0];
								ph = nib[1:0];
								buttons = {~nib[3], ~nib[2], found_port ? ~s.trigger_b : ~s.trigger_a};
								wheel = 16'(wheel + quad_turn[{wheel_phase, ph}]);
								wheel_phase = ph;
							end
							scan_pending = 1'b1;
							started = 1'b1;
						end
					end
				end
				default: ;
			endcase
			r.pos_x = cur_x;
			r.pos_y = cur_y[7:0];
			r.button_bits = buttons;
			r.wheel_count = wheel;
			r.start_scan = started;
			r.device_found = found;
			expected_reports.push_back(r);
		endfunction

		function void compare(string field, int want_v, int got_v);
			if (want_v != got_v) begin
				$error("%s: expected %0d, got %0d", field, want_v, got_v);
				mismatches++;
			end
		endfunction

		function void check_report(result_t got);
			result_t want;
			if (expected_reports.size() == 0) begin
				$error("result word with nothing expected: %h", got);
				mismatches++;
				return;
			end
			want = expected_reports.pop_front();
			compare("pos_x", want.pos_x, got.pos_x);
			compare("pos_y", want.pos_y, got.pos_y);
			compare("button_bits", want.button_bits, got.button_bits);
			compare("wheel_count", want.wheel_count, got.wheel_count);
			compare("start_scan", want.start_scan, got.start_scan);
			compare("device_found", want.device_found, got.device_found);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_data;
	bit         quiet;
	logic [7:0] lines_now;
	logic [6:0] pot_walk[4];
	logic       trig_a;
	logic       trig_b;
	int         home_port;

	pointer_predictor tracker;

	ppt_stream_if #(.word_t(sample_t)) sample_ch ();
	ppt_stream_if #(.word_t(result_t)) result_ch ();

	pointer_position_tracker #(
		.SCREEN_WIDTH(SCR_W),
		.SCREEN_HEIGHT(SCR_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.result(result_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t mk(logic [1:0] op, logic [7:0] lines, logic ta, logic tb_b,
			logic [7:0] pa, logic [7:0] pb, logic [7:0] pc, logic [7:0] pd,
			logic [3:0] busy, logic signed [15:0] tx, logic signed [15:0] ty);
		sample_t s;
		s.opcode = op;
		s.port_lines = lines;
		s.trigger_a = ta;
		s.trigger_b = tb_b;
		s.pot_a = pa;
		s.pot_b = pb;
		s.pot_c = pc;
		s.pot_d = pd;
		s.pots_busy = busy;
		s.target_x = tx;
		s.target_y = ty;
		return s;
	endfunction

	// mostly single-line quadrature steps, and pot readings mostly well-formed on the home port only
	function automatic sample_t next_sample(input logic [2:0] k);
		sample_t    s;
		int         r;
		int         p;
		int         step;
		logic [7:0] w;
		s = '0;
		r = $urandom_range(0, 99);
		if (r < 3)
			s.opcode = OP_INIT;
		else if (r < 6)
			s.opcode = OP_WARP;
		else
			s.opcode = OP_POLL;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			p = $urandom_range(0, 7);
			lines_now[p] = ~lines_now[p];
		end else if (r < 92) begin
			lines_now = 8'($urandom);
		end
		s.port_lines = lines_now;
		if ($urandom_range(0, 99) < 15)
			trig_a = ~trig_a;
		if ($urandom_range(0, 99) < 15)
			trig_b = ~trig_b;
		s.trigger_a = trig_a;
		s.trigger_b = trig_b;
		for (p = 0; p < 4; p++) begin
			if ($urandom_range(0, 99) < 85)
				step = int'($urandom_range(0, 16)) - 8;
			else
				step = $urandom_range(0, 127);
			pot_walk[p] = pot_walk[p] + step[6:0];
			r = $urandom_range(0, 99);
			if (k == KIND_TABLET) begin
				if (r < 5)
					w = 8'd0;
				else if (r < 10)
					w = 8'hFF;
				else if (r < 15)
					w = 8'(POT_CAP);
				else
					w = 8'($urandom);
			end else if ((p >> 1) == home_port && r < 88) begin
				w = {~pot_walk[p][6], pot_walk[p]};
			end else if ((p >> 1) != home_port && r < 80) begin
				w = {pot_walk[p][6], pot_walk[p]};
			end else begin
				w = 8'($urandom);
			end
			case (p)
				0: s.pot_a = w;
				1: s.pot_b = w;
				2: s.pot_c = w;
				default: s.pot_d = w;
			endcase
		end
		s.pots_busy = ($urandom_range(0, 99) < 75) ? 4'd0 : 4'($urandom_range(1, 15));
		if ($urandom_range(0, 1)) begin
			s.target_x = 16'(int'($urandom_range(0, 700)) - 30);
			s.target_y = 16'(int'($urandom_range(0, 280)) - 20);
		end else begin
			s.target_x = 16'($urandom);
			s.target_y = 16'($urandom);
		end
		return s;
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic put_sample(input sample_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.data = w;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		tracker.absorb_sample(w);
		@(negedge clk);
	endtask

	task automatic set_kind(input logic [2:0] k);
		sample_ch.valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = k;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.kind = k;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			tracker.check_report(result_ch.data);
	end

	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ch.ready = 1'b0;
				stall_left--;
			end else begin
				result_ch.ready = 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		#8000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int      phase;
		int      n;
		int      k;
		sample_t s;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = KIND_NONE;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		quiet = 1'b0;
		lines_now = '0;
		for (n = 0; n < 4; n++)
			pot_walk[n] = '0;
		trig_a = 1'b1;
		trig_b = 1'b1;
		home_port = 0;
		tracker = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no device: polls change nothing, init and warp clamp the target
		set_kind(KIND_NONE);
		put_sample(mk(OP_POLL, 8'hFF, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'h0, 0, 0));
		put_sample(mk(OP_INIT, 8'h00, 1, 1, 0, 0, 0, 0, 4'h0, -32768, -32768));
		put_sample(mk(OP_WARP, 8'h00, 1, 1, 0, 0, 0, 0, 4'h0, 32767, 32767));
		put_sample(mk(OP_WARP, 8'h00, 1, 1, 0, 0, 0, 0, 4'h0, 640, 240));

		// quadrature mice, including a step where both lines change
		set_kind(KIND_ST_MOUSE);
		put_sample(mk(OP_INIT, 8'h00, 1, 1, 0, 0, 0, 0, 4'h0, 320, 120));
		put_sample(mk(OP_POLL, 8'h01, 1, 1, 0, 0, 0, 0, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'h03, 1, 1, 0, 0, 0, 0, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'h00, 1, 1, 0, 0, 0, 0, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'hF4, 0, 1, 0, 0, 0, 0, 4'h0, 0, 0));
		set_kind(KIND_ALT_MOUSE);
		put_sample(mk(OP_POLL, 8'h0A, 1, 0, 0, 0, 0, 0, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'h05, 0, 0, 0, 0, 0, 0, 4'h0, 0, 0));
		set_kind(KIND_TRACKBALL);
		put_sample(mk(OP_INIT, 8'h00, 1, 1, 0, 0, 0, 0, 4'h0, 100, 100));
		put_sample(mk(OP_POLL, 8'h02, 1, 1, 0, 0, 0, 0, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'h03, 1, 1, 0, 0, 0, 0, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'h01, 1, 1, 0, 0, 0, 0, 4'h0, 0, 0));

		// tablet: busy scan ignored, readings above the cap
		set_kind(KIND_TABLET);
		put_sample(mk(OP_INIT, 8'h00, 1, 1, 0, 0, 0, 0, 4'h0, 10, 10));
		put_sample(mk(OP_POLL, 8'h00, 0, 0, 8'hFF, 8'hFF, 0, 0, 4'h3, 0, 0));
		put_sample(mk(OP_POLL, 8'h00, 0, 1, 8'hFF, 8'hFF, 0, 0, 4'hC, 0, 0));
		put_sample(mk(OP_POLL, 8'h00, 1, 0, 8'd228, 8'd0, 0, 0, 4'h0, 0, 0));

		// pot mouse: busy, not found, found on port 1, invalid reading, wraps
		set_kind(KIND_POT_MOUSE);
		put_sample(mk(OP_INIT, 8'h00, 1, 1, 0, 0, 0, 0, 4'h0, 300, 100));
		put_sample(mk(OP_POLL, 8'h00, 1, 1, 8'h40, 8'h40, 8'h40, 8'h40, 4'h1, 0, 0));
		put_sample(mk(OP_POLL, 8'h00, 1, 1, 8'h00, 8'hFF, 8'hC0, 8'h3F, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'h00, 1, 1, 8'h00, 8'h40, 8'h80, 8'h7F, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'h10, 1, 0, 8'h00, 8'h00, 8'h84, 8'h7E, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'h30, 1, 1, 8'h00, 8'h00, 8'hC0, 8'h7E, 4'h0, 0, 0));
		put_sample(mk(OP_POLL, 8'hC2, 1, 0, 8'h00, 8'h00, 8'hBF, 8'h41, 4'h0, 0, 0));

		for (phase = 0; phase < 16; phase++) begin
			k = phase % 6;
			set_kind(k[2:0]);
			quiet = (phase % 4 == 3);
			home_port = $urandom_range(0, 1);
			if ($urandom_range(0, 9) < 7) begin
				s = next_sample(k[2:0]);
				s.opcode = OP_INIT;
				put_sample(s);
			end
			for (n = 0; n < 100; n++)
				put_sample(next_sample(k[2:0]));
		end

		sample_ch.valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (tracker.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
